>>> design/granular_pitch_shift_delay_top_assert.svh
// Assertion macros for the granular pitch shift delay block
`ifndef GRANULAR_PITCH_SHIFT_DELAY_TOP_ASSERT_SVH
`define GRANULAR_PITCH_SHIFT_DELAY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GPSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define GPSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define GPSD_ASSERT_IMPL(label, ante, cons)
`define GPSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/gpsd_pkg.sv
// Package: types, constants and window function for the pitch shift delay
package gpsd_pkg;
	localparam int DelayDepthDef = 262144;
	localparam int WindowSizeDef = 1024;
	localparam int SampleWidthDef = 24;
	localparam int SW = 24;
	localparam int FbCap = 62259;
	localparam int Unity = 65536;
	localparam logic [63:0] Pi30 = 64'd3373259426;

	localparam logic [2:0] REG_PITCH = 3'd0;
	localparam logic [2:0] REG_REVERSE = 3'd1;
	localparam logic [2:0] REG_DELAY = 3'd2;
	localparam logic [2:0] REG_GSTEP = 3'd3;
	localparam logic [2:0] REG_FB = 3'd4;
	localparam logic [2:0] REG_MIX = 3'd5;
	localparam logic [2:0] REG_BTGT = 3'd6;
	localparam logic [2:0] REG_BRATE = 3'd7;

	typedef struct packed {
		logic signed [SW-1:0] left_in;
		logic signed [SW-1:0] right_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [SW-1:0] left_out;
		logic signed [SW-1:0] right_out;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] pitch_ratio;
		logic reverse_mode;
		logic [17:0] delay_samples;
		logic [23:0] grain_step;
		logic [15:0] feedback_gain;
		logic [16:0] wet_mix;
		logic [16:0] bypass_target;
		logic [16:0] bypass_rate;
	} cfg_t;

	// controller to datapath commands
	typedef enum logic [3:0] {
		OP_NONE, OP_START, OP_GRAIN, OP_ADDR, OP_RD0, OP_RD1, OP_INTERP, OP_AMP,
		OP_WET, OP_FB, OP_WRITE, OP_MIX, OP_BYP, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		logic grain;
		logic clear_step;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} status_t;

	// half-sine window entry, Q1.16, evaluated at elaboration only
	function automatic logic [16:0] win_value(input int idx, input int size);
		logic [63:0] t, a, term;
		logic signed [63:0] sum, w;
		t = (idx < size - 1 - idx) ? 64'(idx) : 64'(size - 1 - idx);
		a = (Pi30 * t) / 64'(size - 1);
		term = a;
		sum = signed'(a);
		for (int k = 1; k <= 5; k++) begin
			term = (((term * a) >> 30) * a) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) sum = sum - signed'(term);
			else sum = sum + signed'(term);
		end
		w = (sum > 0) ? (sum + 64'sd8192) >>> 14 : 64'sd0;
		if (w > 64'sd65536) w = 64'sd65536;
		return w[16:0];
	endfunction

	function automatic logic signed [SW-1:0] sat_s(input logic signed [63:0] x);
		logic signed [63:0] hi, lo;
		hi = (64'sd1 <<< (SW - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi) return hi[SW-1:0];
		if (x < lo) return lo[SW-1:0];
		return x[SW-1:0];
	endfunction
endpackage

>>> design/gpsd_ctrl.sv
// Controller: sequences one frame through the datapath
module gpsd_ctrl import gpsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output cmd_t cmd,
	input status_t status
);
	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_GRAIN, S_DRAIN} state_t;
	state_t state_q;
	logic [3:0] step_q;
	logic grain_q;
	logic out_valid_q;
	logic out_fire_c;
	op_t op_c;

	// hold the last step while the previous beat still waits
	assign out_fire_c = (state_q == S_DRAIN) && (step_q == 4'd4)
		&& !(out_valid_q && out_stall);
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		op_c = OP_NONE;
		unique case (state_q)
			S_IDLE: op_c = (in_valid && !in_stall) ? OP_START : OP_NONE;
			S_GRAIN: begin
				unique case (step_q)
					4'd0: op_c = OP_GRAIN;
					4'd1: op_c = OP_ADDR;
					4'd2: op_c = OP_RD0;
					4'd3: op_c = OP_RD1;
					4'd4: op_c = OP_INTERP;
					4'd5: op_c = OP_AMP;
					default: op_c = OP_WET;
				endcase
			end
			S_DRAIN: begin
				unique case (step_q)
					4'd0: op_c = OP_FB;
					4'd1: op_c = OP_WRITE;
					4'd2: op_c = OP_MIX;
					4'd3: op_c = OP_BYP;
					default: op_c = out_fire_c ? OP_OUT : OP_NONE;
				endcase
			end
			default: op_c = OP_NONE;
		endcase
	end

	assign cmd = '{op: op_c, grain: grain_q, clear_step: state_q == S_CLEAR};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q <= '0;
			grain_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_fire_c) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: if (status.clear_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= S_GRAIN;
						step_q <= '0;
						grain_q <= 1'b0;
					end
				end
				S_GRAIN: begin
					if (step_q == 4'd6) begin
						step_q <= '0;
						grain_q <= ~grain_q;
						if (grain_q) state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DRAIN: begin
					if (step_q == 4'd4) begin
						if (out_fire_c) state_q <= S_IDLE;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/gpsd_dp.sv
// Datapath: delay lines, grain state, window table and mix arithmetic
module gpsd_dp import gpsd_pkg::*; #(
	parameter int DELAY_DEPTH = DelayDepthDef,
	parameter int WINDOW_SIZE = WindowSizeDef
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input in_beat_t in_beat,
	input cmd_t cmd,
	output status_t status,
	output out_beat_t out_beat
);
	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int PW = AW + 16;
	localparam int WW = $clog2(WINDOW_SIZE);

	logic signed [SW-1:0] left_mem [DELAY_DEPTH];
	logic signed [SW-1:0] right_mem [DELAY_DEPTH];
	logic [16:0] win_rom [WINDOW_SIZE];

	initial begin
		for (int n = 0; n < WINDOW_SIZE; n++) win_rom[n] = win_value(n, WINDOW_SIZE);
	end

	logic [AW-1:0] clr_q;
	logic clr_done_q;
	logic [AW-1:0] wr_idx_q;
	logic [PW-1:0] pos_q [2];
	logic [23:0] prog_q [2];
	logic signed [17:0] byp_q;
	logic signed [SW-1:0] inl_q, inr_q;
	logic [AW-1:0] rd_addr_q;
	logic [15:0] frac_q;
	logic signed [SW-1:0] l0_q, r0_q, l1_q, r1_q, rdl_q, rdr_q;
	logic [WW-1:0] wi0_q;
	logic [23:0] wf_q;
	logic signed [17:0] w0_q, w1_q;
	logic signed [17:0] amp_q;
	logic signed [SW+3:0] wl_q, wr_q;
	logic signed [SW-1:0] fl_q, fr_q;
	logic signed [SW+3:0] ml_q, mr_q;
	logic signed [SW-1:0] outl_q, outr_q;

	assign status.clear_done = clr_done_q;
	assign out_beat = '{left_out: outl_q, right_out: outr_q};

	logic [16:0] fb_c, mix_c, tgt_c, rate_c;
	assign fb_c = (cfg.feedback_gain > 16'(FbCap)) ? 17'(FbCap) : 17'(cfg.feedback_gain);
	assign mix_c = (cfg.wet_mix > 17'(Unity)) ? 17'(Unity) : cfg.wet_mix;
	assign tgt_c = (cfg.bypass_target > 17'(Unity)) ? 17'(Unity) : cfg.bypass_target;
	assign rate_c = (cfg.bypass_rate > 17'(Unity)) ? 17'(Unity) : cfg.bypass_rate;

	logic [PW-1:0] sp_c, pnext_c, pcur_c;
	logic [24:0] prog_sum_c;
	logic [AW-1:0] restart_c;
	logic [WW+24:0] lp_c;
	logic [WW-1:0] i0_c;
	assign pcur_c = pos_q[cmd.grain];
	assign sp_c = PW'(cfg.pitch_ratio) << 4;
	assign pnext_c = cfg.reverse_mode ? pcur_c - sp_c : pcur_c + sp_c;
	assign prog_sum_c = 25'(prog_q[cmd.grain]) + 25'(cfg.grain_step);
	assign restart_c = wr_idx_q - AW'(cfg.delay_samples);
	assign lp_c = (WW+25)'(prog_q[cmd.grain]) * (WW+25)'(WINDOW_SIZE - 1);
	assign i0_c = lp_c[WW+23:24];

	logic [WW-1:0] wi1_c;
	logic signed [47:0] wprod_c;
	assign wi1_c = (wi0_q == WW'(WINDOW_SIZE - 1)) ? wi0_q : wi0_q + WW'(1);
	assign wprod_c = 48'(w1_q - w0_q) * signed'({24'd0, wf_q});

	logic signed [SW+17:0] dl_c, dr_c;
	assign dl_c = 42'(l1_q - l0_q) * signed'({1'b0, frac_q});
	assign dr_c = 42'(r1_q - r0_q) * signed'({1'b0, frac_q});

	logic signed [63:0] al_c, ar_c;
	assign al_c = 64'(rdl_q) * 64'(amp_q) + 64'sd32768;
	assign ar_c = 64'(rdr_q) * 64'(amp_q) + 64'sd32768;

	logic signed [63:0] tl_c, tr_c, xl_c, xr_c, bl_c, br_c, by_c;
	assign tl_c = 64'(wl_q) * signed'({47'd0, fb_c}) + 64'sd32768;
	assign tr_c = 64'(wr_q) * signed'({47'd0, fb_c}) + 64'sd32768;
	assign xl_c = 64'(inl_q) * signed'({47'd0, 17'(Unity) - mix_c})
		+ 64'(wl_q) * signed'({47'd0, mix_c}) + 64'sd32768;
	assign xr_c = 64'(inr_q) * signed'({47'd0, 17'(Unity) - mix_c})
		+ 64'(wr_q) * signed'({47'd0, mix_c}) + 64'sd32768;
	assign bl_c = 64'(byp_q) * (64'(inl_q) - 64'(ml_q)) + 64'sd32768;
	assign br_c = 64'(byp_q) * (64'(inr_q) - 64'(mr_q)) + 64'sd32768;
	assign by_c = (64'(signed'({1'b0, tgt_c})) - 64'(byp_q)) * signed'({47'd0, rate_c})
		+ 64'sd32768;

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			left_mem[clr_q] <= '0;
			right_mem[clr_q] <= '0;
		end else if (cmd.op == OP_WRITE) begin
			left_mem[wr_idx_q] <= fl_q;
			right_mem[wr_idx_q] <= fr_q;
		end
		if (cmd.op == OP_RD0) begin
			l0_q <= left_mem[rd_addr_q];
			r0_q <= right_mem[rd_addr_q];
			w0_q <= signed'({1'b0, win_rom[wi0_q]});
			w1_q <= signed'({1'b0, win_rom[wi1_c]});
		end
		if (cmd.op == OP_RD1) begin
			l1_q <= left_mem[rd_addr_q];
			r1_q <= right_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_done_q <= 1'b0;
			wr_idx_q <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			prog_q[0] <= '0;
			prog_q[1] <= 24'h800000;
			byp_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(DELAY_DEPTH - 1)) clr_done_q <= 1'b1;
			end
			unique case (cmd.op)
				OP_START: byp_q <= byp_q + 18'(by_c >>> 16);
				OP_GRAIN: begin
					if (prog_sum_c[24]) begin
						prog_q[cmd.grain] <= '0;
						pos_q[cmd.grain] <= {restart_c, 16'd0};
					end else begin
						prog_q[cmd.grain] <= prog_sum_c[23:0];
						pos_q[cmd.grain] <= pnext_c;
					end
				end
				OP_WRITE: wr_idx_q <= wr_idx_q + AW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				inl_q <= in_beat.left_in;
				inr_q <= in_beat.right_in;
				wl_q <= '0;
				wr_q <= '0;
			end
			OP_ADDR: begin
				rd_addr_q <= pcur_c[PW-1:16];
				frac_q <= pcur_c[15:0];
				wi0_q <= i0_c;
				wf_q <= lp_c[23:0];
			end
			OP_RD0: rd_addr_q <= rd_addr_q + AW'(1);
			OP_INTERP: begin
				rdl_q <= l0_q + SW'((dl_c + 42'sd32768) >>> 16);
				rdr_q <= r0_q + SW'((dr_c + 42'sd32768) >>> 16);
			end
			OP_AMP: amp_q <= w0_q + 18'((wprod_c + 48'sd8388608) >>> 24);
			OP_WET: begin
				wl_q <= wl_q + (SW+4)'(al_c >>> 16);
				wr_q <= wr_q + (SW+4)'(ar_c >>> 16);
			end
			OP_FB: begin
				fl_q <= sat_s(64'(inl_q) + (tl_c >>> 16));
				fr_q <= sat_s(64'(inr_q) + (tr_c >>> 16));
			end
			OP_MIX: begin
				ml_q <= (SW+4)'(xl_c >>> 16);
				mr_q <= (SW+4)'(xr_c >>> 16);
			end
			OP_OUT: begin
				outl_q <= sat_s(64'(ml_q) + (bl_c >>> 16));
				outr_q <= sat_s(64'(mr_q) + (br_c >>> 16));
			end
			default: ;
		endcase
	end
endmodule

>>> design/granular_pitch_shift_delay_top.sv
// Top level: two-grain pitch shifting stereo delay
// The output step waits while a previous output beat is still stalled.
// Each frame runs through the sequencer's two grain passes of seven steps each over the single
// delay line port, then five output steps; no new input is taken until the frame is done.
// Reset: control and configuration registers take defaults; the delay lines are then cleared,
// one entry per cycle, and no input is taken until every entry is cleared.
module granular_pitch_shift_delay_top import gpsd_pkg::*; #(
	parameter int DELAY_DEPTH = DelayDepthDef,
	parameter int WINDOW_SIZE = WindowSizeDef
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_beat_t out_data
);
	`include "granular_pitch_shift_delay_top_assert.svh"
	cfg_t cfg_q;
	cmd_t cmd;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pitch_ratio: 16'd8192, reverse_mode: 1'b0, delay_samples: 18'd22050,
				grain_step: 24'd3804, feedback_gain: 16'd32768, wet_mix: 17'd32768,
				bypass_target: 17'd0, bypass_rate: 17'd66};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PITCH: cfg_q.pitch_ratio <= cfg_data[15:0];
				REG_REVERSE: cfg_q.reverse_mode <= cfg_data[0];
				REG_DELAY: cfg_q.delay_samples <= cfg_data[17:0];
				REG_GSTEP: cfg_q.grain_step <= cfg_data;
				REG_FB: cfg_q.feedback_gain <= cfg_data[15:0];
				REG_MIX: cfg_q.wet_mix <= cfg_data[16:0];
				REG_BTGT: cfg_q.bypass_target <= cfg_data[16:0];
				default: cfg_q.bypass_rate <= cfg_data[16:0];
			endcase
		end
	end

	gpsd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
	);

	gpsd_dp #(.DELAY_DEPTH(DELAY_DEPTH), .WINDOW_SIZE(WINDOW_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_beat(in_data), .cmd(cmd),
		.status(status), .out_beat(out_data)
	);

	`GPSD_ASSERT_IMPL(a_no_take_in_clear, !status.clear_done, in_stall)
	`GPSD_ASSERT_NEXT(a_start_not_again, cmd.op == OP_START, in_stall)
	`GPSD_ASSERT_IMPL(a_out_not_busy, out_valid && out_stall, cmd.op != OP_OUT)
endmodule
